### rtl/core/kav_pkg.sv
package kav_pkg;

  localparam int COV_WIDTH_DEF = 48;
  localparam int DT_FRAC       = 16;
  localparam int VAR_FRAC      = 16;
  localparam int DT_W          = 18;
  localparam int DT2_W         = 36;
  localparam int DT3_W         = 38;
  localparam int DT4_W         = 40;
  localparam int SH_W          = 6;

  // one request to the shared multiplier: sign, magnitudes, shift, clamp limit
  typedef struct packed {
    logic            neg;
    logic [63:0]     ua;
    logic [63:0]     ub;
    logic [SH_W-1:0] sh;
    logic [63:0]     cap;
  } mul_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_INNOV,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_DT2,
    OP_DT3,
    OP_DT4,
    OP_POS,
    OP_PP1,
    OP_PP2,
    OP_PP3,
    OP_PV1,
    OP_PV2,
    OP_VV1,
    OP_KP,
    OP_KV,
    OP_CP,
    OP_CV,
    OP_C1,
    OP_C2,
    OP_C3
  } op_t;

endpackage

### rtl/core/kav_mul.sv
module kav_mul (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  kav_pkg::mul_req_t   req,
  output logic                done,
  output logic signed [63:0]  res,
  output logic                sat
);
  import kav_pkg::*;

  logic         busy;
  logic [2:0]   cnt;
  mul_req_t     rq;
  logic [63:0]  pp;
  logic [1:0]   pp_pos;
  logic [127:0] acc;
  logic [31:0]  a_h;
  logic [31:0]  b_h;
  logic [63:0]  prod;
  logic [127:0] pp_ext;
  logic [127:0] shifted;
  logic [63:0]  m;
  logic [63:0]  mval;
  logic         over;

  // partial products in order lo*lo, lo*hi, hi*lo, hi*hi
  assign a_h  = cnt[1] ? rq.ua[63:32] : rq.ua[31:0];
  assign b_h  = cnt[0] ? rq.ub[63:32] : rq.ub[31:0];
  assign prod = a_h * b_h;

  always_comb begin
    unique case (pp_pos)
      2'd0:       pp_ext = {64'd0, pp};
      2'd1, 2'd2: pp_ext = {32'd0, pp, 32'd0};
      2'd3:       pp_ext = {pp, 64'd0};
    endcase
  end

  assign shifted = acc >> rq.sh;
  assign m       = shifted[63:0];
  assign over    = (|shifted[127:64]) || (m > rq.cap);
  assign mval    = over ? rq.cap : m;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rq <= req;
      // preload the rounding half so the final shift rounds away from zero
      if (req.sh == '0) begin
        acc <= 128'd0;
      end else begin
        acc <= 128'd1 << (req.sh - 6'd1);
      end
    end else if (busy) begin
      if (cnt < 3'd4) begin
        pp     <= prod;
        pp_pos <= cnt[1:0];
      end
      if (cnt >= 3'd1 && cnt <= 3'd4) begin
        acc <= acc + pp_ext;
      end
      if (cnt == 3'd5) begin
        sat <= over;
        res <= rq.neg ? -mval : mval;
      end
    end
  end

endmodule

### rtl/core/kav_div.sv
module kav_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);
  import kav_pkg::*;

  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] rem;
  logic [63:0] d;
  logic [64:0] shifted;
  logic [64:0] diff;
  logic        ge;

  assign shifted = {rem, quo[63]};
  assign ge      = shifted >= {1'b0, d};
  assign diff    = shifted - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 6'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= 64'd0;
      quo <= num;
      d   <= den;
    end else if (busy) begin
      rem <= ge ? diff[63:0] : shifted[63:0];
      quo <= {quo[62:0], ge};
    end
  end

endmodule

### rtl/core/kalman_altitude_velocity_filter.sv
// Two-state (position, velocity) Kalman filter, constant-velocity model.
// Config: write accel_variance through cfg_valid/cfg_ready (always ready),
//   only while the block is idle.
// Input: measured_position, measurement_variance, time_step, taken on
//   in_valid & in_ready. in_ready is high only while no item is in work.
// Output: position_estimate, velocity_estimate, degenerate_flag,
//   saturated_flag, one item per input on out_valid & out_ready.
// Work: one shared 32x32 multiplier forms 17 products of up to 64x64
//   bits when the correction runs, 10 when the innovation variance is not
//   positive and the correction is skipped; a radix-2 divider forms the
//   reciprocal. The next item is taken only once the last one's result
//   has gone to the output register.
// A result sits in an output register; the next item is accepted while it
//   waits, and the block holds its finished next result until the receiver
//   takes the pending one.
// Reset clears the state, the covariance and accel_variance to zero.
module kalman_altitude_velocity_filter #(
  parameter int COV_WIDTH = kav_pkg::COV_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [31:0]               accel_variance,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [31:0]        measured_position,
  input  logic [31:0]               measurement_variance,
  input  logic [kav_pkg::DT_W-1:0]  time_step,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [31:0]        position_estimate,
  output logic signed [31:0]        velocity_estimate,
  output logic                      degenerate_flag,
  output logic                      saturated_flag
);
  import kav_pkg::*;

  localparam int CF    = COV_WIDTH / 2;
  localparam int RC_SH = CF - VAR_FRAC;
  localparam logic [63:0] CLIM = (64'd1 << (COV_WIDTH - 1)) - 64'd1;
  localparam logic [63:0] SLIM = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] MAXL = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [SH_W-1:0] SH_Q4 = SH_W'(VAR_FRAC + 32 + 2 - CF);
  localparam logic [SH_W-1:0] SH_Q3 = SH_W'(VAR_FRAC + 32 + 1 - CF);
  localparam logic [SH_W-1:0] SH_Q2 = SH_W'(VAR_FRAC + 32 - CF);
  localparam logic [SH_W-1:0] SH_K  = SH_W'(63 - CF);
  localparam logic [SH_W-1:0] SH_C  = SH_W'(CF);
  localparam logic [SH_W-1:0] SH_DT = SH_W'(DT_FRAC);

  state_t state;
  state_t state_next;
  op_t    op;

  logic [31:0]                 accel_var;
  logic signed [31:0]          z;
  logic [31:0]                 rvar;
  logic [DT_W-1:0]             dt;
  logic [DT2_W-1:0]            dt2;
  logic [DT3_W-1:0]            dt3;
  logic [DT4_W-1:0]            dt4;
  logic signed [31:0]          pos;
  logic signed [31:0]          vel;
  logic signed [COV_WIDTH-1:0] ppp;
  logic signed [COV_WIDTH-1:0] ppv;
  logic signed [COV_WIDTH-1:0] pvv;
  logic signed [COV_WIDTH-1:0] kp;
  logic signed [COV_WIDTH-1:0] kv;
  logic signed [32:0]          y;
  logic [63:0]                 recip;
  logic                        sat_acc;
  logic                        degen;

  logic               mul_start;
  mul_req_t           mreq;
  logic               mul_done;
  logic signed [63:0] mul_res;
  logic               mul_sat;
  logic               div_start;
  logic               div_done;
  logic [63:0]        div_quo;
  logic [63:0]        div_num;
  logic               load_out;

  logic signed [63:0] a_val;
  logic signed [63:0] b_val;
  logic               a_sgn;
  logic               b_sgn;
  logic               a_neg;
  logic               b_neg;
  logic [SH_W-1:0]    sh;
  logic [63:0]        lim;

  logic signed [63:0] dst;
  logic [63:0]        add_lim;
  logic               add_sub;
  logic               add_use;
  logic signed [65:0] add_sum;
  logic [64:0]        add_res;

  logic [63:0]        rc_raw;
  logic               rc_sat;
  logic [63:0]        rc;
  logic [64:0]        s_res;
  logic [63:0]        s_val;
  logic               s_pos;

  // clamp a wide sum to [-l-1, l]; returns {clamped, value}
  function automatic logic [64:0] clamp(input logic signed [65:0] v, input logic [63:0] l);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = $signed({2'b00, l});
    lo = -hi - 66'sd1;
    if (v > hi) begin
      clamp = {1'b1, hi[63:0]};
    end else if (v < lo) begin
      clamp = {1'b1, lo[63:0]};
    end else begin
      clamp = {1'b0, v[63:0]};
    end
  endfunction

  assign cfg_ready = 1'b1;

  // operand select for the shared multiplier
  always_comb begin
    a_val = 64'(dt);
    b_val = 64'(dt);
    a_sgn = 1'b0;
    b_sgn = 1'b0;
    sh    = '0;
    lim   = MAXL;
    unique case (op)
      OP_DT2: begin
        a_val = 64'(dt);  b_val = 64'(dt);  sh = '0;  lim = MAXL;
      end
      OP_DT3: begin
        a_val = 64'(dt2); b_val = 64'(dt);  sh = SH_DT; lim = MAXL;
      end
      OP_DT4: begin
        a_val = 64'(dt2); b_val = 64'(dt2); sh = SH_W'(32); lim = MAXL;
      end
      OP_POS: begin
        a_val = 64'(vel); a_sgn = 1'b1; b_val = 64'(dt); sh = SH_DT; lim = SLIM;
      end
      OP_PP1: begin
        a_val = 64'(ppv); a_sgn = 1'b1; b_val = 64'(dt); sh = SH_DT - 6'd1; lim = CLIM;
      end
      OP_PP2: begin
        a_val = 64'(pvv); a_sgn = 1'b1; b_val = 64'(dt2); sh = SH_W'(32); lim = CLIM;
      end
      OP_PP3: begin
        a_val = 64'(accel_var); b_val = 64'(dt4); sh = SH_Q4; lim = CLIM;
      end
      OP_PV1: begin
        a_val = 64'(pvv); a_sgn = 1'b1; b_val = 64'(dt); sh = SH_DT; lim = CLIM;
      end
      OP_PV2: begin
        a_val = 64'(accel_var); b_val = 64'(dt3); sh = SH_Q3; lim = CLIM;
      end
      OP_VV1: begin
        a_val = 64'(accel_var); b_val = 64'(dt2); sh = SH_Q2; lim = CLIM;
      end
      OP_KP: begin
        a_val = 64'(ppp); a_sgn = 1'b1; b_val = recip; sh = SH_K; lim = CLIM;
      end
      OP_KV: begin
        a_val = 64'(ppv); a_sgn = 1'b1; b_val = recip; sh = SH_K; lim = CLIM;
      end
      OP_CP: begin
        a_val = 64'(y); a_sgn = 1'b1; b_val = 64'(kp); b_sgn = 1'b1; sh = SH_C; lim = SLIM;
      end
      OP_CV: begin
        a_val = 64'(y); a_sgn = 1'b1; b_val = 64'(kv); b_sgn = 1'b1; sh = SH_C; lim = SLIM;
      end
      OP_C1: begin
        a_val = 64'(ppv); a_sgn = 1'b1; b_val = 64'(kv); b_sgn = 1'b1; sh = SH_C; lim = CLIM;
      end
      OP_C2: begin
        a_val = 64'(ppv); a_sgn = 1'b1; b_val = 64'(kp); b_sgn = 1'b1; sh = SH_C; lim = CLIM;
      end
      OP_C3: begin
        a_val = 64'(ppp); a_sgn = 1'b1; b_val = 64'(kp); b_sgn = 1'b1; sh = SH_C; lim = CLIM;
      end
    endcase
  end

  assign a_neg    = a_sgn & a_val[63];
  assign b_neg    = b_sgn & b_val[63];
  assign mreq.neg = a_neg ^ b_neg;
  assign mreq.ua  = a_neg ? -a_val : a_val;
  assign mreq.ub  = b_neg ? -b_val : b_val;
  assign mreq.sh  = sh;
  assign mreq.cap = lim + {63'd0, a_neg ^ b_neg};

  // add or subtract the product into its destination with clamping; unused for the step powers and gains
  always_comb begin
    dst     = 64'(ppp);
    add_lim = CLIM;
    add_sub = 1'b0;
    add_use = 1'b1;
    unique case (op)
      OP_DT2, OP_DT3, OP_DT4, OP_KP, OP_KV: add_use = 1'b0;
      OP_POS, OP_CP:          begin dst = 64'(pos); add_lim = SLIM; end
      OP_CV:                  begin dst = 64'(vel); add_lim = SLIM; end
      OP_PP1, OP_PP2, OP_PP3: dst = 64'(ppp);
      OP_PV1, OP_PV2:         dst = 64'(ppv);
      OP_VV1:                 dst = 64'(pvv);
      OP_C1:                  begin dst = 64'(pvv); add_sub = 1'b1; end
      OP_C2:                  begin dst = 64'(ppv); add_sub = 1'b1; end
      OP_C3:                  begin dst = 64'(ppp); add_sub = 1'b1; end
    endcase
  end

  assign add_sum = add_sub ? (66'(dst) - 66'(mul_res)) : (66'(dst) + 66'(mul_res));
  assign add_res = clamp(add_sum, add_lim);

  // innovation variance and the divider operands
  assign rc_raw  = 64'(rvar) << RC_SH;
  assign rc_sat  = rc_raw > CLIM;
  assign rc      = rc_sat ? CLIM : rc_raw;
  assign s_res   = clamp(66'(ppp) + $signed({2'b00, rc}), CLIM);
  assign s_val   = s_res[63:0];
  assign s_pos   = !s_val[63] && (s_val != 64'd0);
  assign div_num = 64'h8000_0000_0000_0000 + (s_val >> 1);

  kav_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .req   (mreq),
    .done  (mul_done),
    .res   (mul_res),
    .sat   (mul_sat)
  );

  kav_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (s_val),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_ISSUE;
      ST_ISSUE: state_next = ST_WAIT;
      ST_WAIT: begin
        if (mul_done) begin
          priority if (op == OP_VV1) state_next = ST_INNOV;
          else if (op == OP_C3)      state_next = ST_DONE;
          else                       state_next = ST_ISSUE;
        end
      end
      ST_INNOV: state_next = s_pos ? ST_DIV : ST_DONE;
      ST_DIV:   if (div_done) state_next = ST_ISSUE;
      ST_DONE:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    mul_start = (state == ST_ISSUE);
    div_start = (state == ST_INNOV) && s_pos;
    load_out  = (state == ST_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= OP_DT2;
      accel_var <= 32'd0;
      pos       <= '0;
      vel       <= '0;
      ppp       <= '0;
      ppv       <= '0;
      pvv       <= '0;
      sat_acc   <= 1'b0;
      degen     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        accel_var <= accel_variance;
      end
      if (in_valid && in_ready) begin
        op      <= OP_DT2;
        sat_acc <= 1'b0;
        degen   <= 1'b0;
      end
      if (state == ST_WAIT && mul_done) begin
        sat_acc <= sat_acc | mul_sat | (add_use & add_res[64]);
        unique case (op)
          OP_POS, OP_CP:          pos <= 32'(add_res[63:0]);
          OP_CV:                  vel <= 32'(add_res[63:0]);
          OP_PP1, OP_PP2, OP_PP3,
          OP_C3:                  ppp <= COV_WIDTH'(add_res[63:0]);
          OP_PV1, OP_PV2, OP_C2:  ppv <= COV_WIDTH'(add_res[63:0]);
          OP_VV1, OP_C1:          pvv <= COV_WIDTH'(add_res[63:0]);
          OP_DT2, OP_DT3, OP_DT4,
          OP_KP, OP_KV:           ;
        endcase
        if (op != OP_VV1 && op != OP_C3) begin
          op <= op_t'(op + 5'd1);
        end
      end
      if (state == ST_INNOV) begin
        sat_acc <= sat_acc | rc_sat | s_res[64];
        degen   <= !s_pos;
        op      <= OP_KP;
      end
      // hold a pending result; drop it once taken
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      z    <= measured_position;
      rvar <= measurement_variance;
      dt   <= time_step;
    end
    if (state == ST_WAIT && mul_done) begin
      unique case (op)
        OP_DT2: dt2 <= DT2_W'(mul_res);
        OP_DT3: dt3 <= DT3_W'(mul_res);
        OP_DT4: dt4 <= DT4_W'(mul_res);
        OP_KP:  kp  <= COV_WIDTH'(mul_res);
        OP_KV:  kv  <= COV_WIDTH'(mul_res);
        OP_POS, OP_PP1, OP_PP2, OP_PP3, OP_PV1, OP_PV2, OP_VV1,
        OP_CP, OP_CV, OP_C1, OP_C2, OP_C3: ;
      endcase
    end
    if (state == ST_INNOV) begin
      y <= 33'(z) - 33'(pos);
    end
    if (state == ST_DIV && div_done) begin
      recip <= div_quo;
    end
    if (load_out) begin
      position_estimate <= pos;
      velocity_estimate <= vel;
      degenerate_flag   <= degen;
      saturated_flag    <= sat_acc;
    end
  end

endmodule

### sim/tb.sv
module tb;
  import kav_pkg::*;

  localparam int  WATCHDOG_LIMIT = 20000;
  localparam int  SETTLE_CYCLES  = 250;
  localparam longint STATE_LIM   = 64'sd2147483647;
  localparam longint COV_LIM     = (64'sd1 <<< (COV_WIDTH_DEF - 1)) - 1;
  localparam longint U64_LIM     = 64'h7fff_ffff_ffff_ffff;
  localparam int  COV_FRAC       = COV_WIDTH_DEF / 2;

  typedef struct {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic               degen;
    logic               sat;
  } estimate_t;

  // Tracks the filter state alongside the block and checks its estimates.
  class track_checker;
    bit [63:0] q;
    longint    pos, vel, cpp, cpv, cvv;
    bit        clamped;
    estimate_t est_q[$];
    int        mismatches, checked, degen_seen, sat_seen;

    function new();
      q = 0; pos = 0; vel = 0; cpp = 0; cpv = 0; cvv = 0;
      mismatches = 0; checked = 0; degen_seen = 0; sat_seen = 0;
    endfunction

    function void set_accel_var(bit [31:0] v);
      q = {32'b0, v};
    endfunction

    function bit [63:0] mag(longint a);
      return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    // exact product, round half away from zero, clamp to the signed range
    function longint mul_round(bit neg, bit [63:0] ua, bit [63:0] ub, int sh, longint lim);
      bit [127:0] p;
      bit [127:0] cap;
      p = {64'b0, ua} * {64'b0, ub};
      p = (p + (128'd1 << (sh - 1))) >> sh;
      cap = 128'(lim) + neg;
      if (p > cap) begin
        clamped = 1;
        p = cap;
      end
      return neg ? longint'(-p[63:0]) : longint'(p[63:0]);
    endfunction

    function longint mul_su(longint a, bit [63:0] b, int sh, longint lim);
      return mul_round(a < 0, mag(a), b, sh, lim);
    endfunction

    function longint mul_ss(longint a, longint b, int sh, longint lim);
      return mul_round((a < 0) != (b < 0), mag(a), mag(b), sh, lim);
    endfunction

    function longint add_clamp(longint a, longint b, longint lim);
      logic signed [65:0] r;
      r = 66'(a) + 66'(b);
      if (r > lim) begin
        clamped = 1;
        return lim;
      end
      if (r < -lim - 1) begin
        clamped = 1;
        return -lim - 1;
      end
      return longint'(r);
    endfunction

    function void note_measurement(logic signed [31:0] z, bit [31:0] rvar, bit [17:0] ts);
      bit [63:0] dt, dt2, dt3, dt4, rc, us, recip;
      longint    ppp, ppv, pvv, y, s, kp, kv;
      estimate_t e;
      clamped = 0;
      e.degen = 0;
      dt  = {46'b0, ts};
      dt2 = dt * dt;
      dt3 = (dt2 * dt + (64'd1 << 15)) >> DT_FRAC;
      dt4 = 64'(mul_round(0, dt2, dt2, 32, U64_LIM));

      pos = add_clamp(pos, mul_su(vel, dt, DT_FRAC, STATE_LIM), STATE_LIM);
      ppp = cpp; ppv = cpv; pvv = cvv;
      cpp = add_clamp(ppp, mul_su(ppv, dt, DT_FRAC - 1, COV_LIM), COV_LIM);
      cpp = add_clamp(cpp, mul_su(pvv, dt2, 32, COV_LIM), COV_LIM);
      cpp = add_clamp(cpp, mul_su(longint'(q), dt4, VAR_FRAC + 34 - COV_FRAC, COV_LIM),
                      COV_LIM);
      cpv = add_clamp(ppv, mul_su(pvv, dt, DT_FRAC, COV_LIM), COV_LIM);
      cpv = add_clamp(cpv, mul_su(longint'(q), dt3, VAR_FRAC + 33 - COV_FRAC, COV_LIM),
                      COV_LIM);
      cvv = add_clamp(pvv, mul_su(longint'(q), dt2, VAR_FRAC + 32 - COV_FRAC, COV_LIM),
                      COV_LIM);

      y  = longint'(z) - pos;
      rc = {32'b0, rvar} << (COV_FRAC - VAR_FRAC);
      if (rc > 64'(COV_LIM)) begin
        clamped = 1;
        rc = 64'(COV_LIM);
      end
      s = add_clamp(cpp, longint'(rc), COV_LIM);

      if (s <= 0) begin
        e.degen = 1;
      end else begin
        us = 64'(s);
        recip = ((64'd1 << 63) + us / 2) / us;
        kp = mul_su(cpp, recip, 63 - COV_FRAC, COV_LIM);
        kv = mul_su(cpv, recip, 63 - COV_FRAC, COV_LIM);
        pos = add_clamp(pos, mul_ss(y, kp, COV_FRAC, STATE_LIM), STATE_LIM);
        vel = add_clamp(vel, mul_ss(y, kv, COV_FRAC, STATE_LIM), STATE_LIM);
        ppp = cpp; ppv = cpv;
        cvv = add_clamp(cvv, -mul_ss(ppv, kv, COV_FRAC, COV_LIM), COV_LIM);
        cpv = add_clamp(ppv, -mul_ss(ppv, kp, COV_FRAC, COV_LIM), COV_LIM);
        cpp = add_clamp(ppp, -mul_ss(ppp, kp, COV_FRAC, COV_LIM), COV_LIM);
      end
      e.pos = pos[31:0];
      e.vel = vel[31:0];
      e.sat = clamped;
      est_q.push_back(e);
    endfunction

    function void check_estimate(estimate_t got);
      estimate_t e;
      if (est_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: estimate with nothing pending: pos=%0d vel=%0d", got.pos, got.vel);
        return;
      end
      e = est_q.pop_front();
      checked++;
      if (got.degen) degen_seen++;
      if (got.sat) sat_seen++;
      if (got.pos !== e.pos || got.vel !== e.vel || got.degen !== e.degen ||
          got.sat !== e.sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: estimate %0d: exp pos=%0d vel=%0d degen=%0b sat=%0b, got pos=%0d vel=%0d degen=%0b sat=%0b",
                   checked, e.pos, e.vel, e.degen, e.sat, got.pos, got.vel, got.degen,
                   got.sat);
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [31:0]        accel_variance = '0;
  logic               in_valid = 0;
  logic               in_ready;
  logic signed [31:0] measured_position = '0;
  logic [31:0]        measurement_variance = '0;
  logic [DT_W-1:0]    time_step = '0;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [31:0] position_estimate;
  logic signed [31:0] velocity_estimate;
  logic               degenerate_flag;
  logic               saturated_flag;

  kalman_altitude_velocity_filter dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .accel_variance(accel_variance),
    .in_valid(in_valid), .in_ready(in_ready),
    .measured_position(measured_position), .measurement_variance(measurement_variance),
    .time_step(time_step),
    .out_valid(out_valid), .out_ready(out_ready),
    .position_estimate(position_estimate), .velocity_estimate(velocity_estimate),
    .degenerate_flag(degenerate_flag), .saturated_flag(saturated_flag)
  );

  track_checker tracker = new();
  int     send_idle = 0, recv_idle = 0;
  int     quiet_cycles = 0;
  int     items_sent = 0;
  longint true_pos = 0, true_vel = 0;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else     out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    estimate_t got;
    if (!rst && out_valid && out_ready) begin
      got.pos = position_estimate;
      got.vel = velocity_estimate;
      got.degen = degenerate_flag;
      got.sat = saturated_flag;
      tracker.check_estimate(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: watchdog expired with %0d estimates pending", tracker.est_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_measurement(logic signed [31:0] z, bit [31:0] rvar, bit [17:0] ts);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    measured_position <= z;
    measurement_variance <= rvar;
    time_step <= ts;
    do @(posedge clk); while (!in_ready);
    tracker.note_measurement(z, rvar, ts);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (tracker.est_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_accel_var(bit [31:0] v);
    drain();
    cfg_valid <= 1;
    accel_variance <= v;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_accel_var(v);
    cfg_valid <= 0;
  endtask

  // mostly a plausible climb or descent with noisy readings, some fully random items
  task automatic send_random(int n);
    longint    z;
    bit [17:0] ts;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80) begin
        ts = 18'($urandom_range(16'h4000, 16'h0200));
        if ($urandom_range(9) == 0) true_vel = $signed($urandom_range(20000, 0)) * 64 - 640000;
        true_pos += (true_vel * longint'(ts)) >>> DT_FRAC;
        if (true_pos > 64'sd100000000 || true_pos < -64'sd100000000) true_pos = 0;
        z = true_pos + $signed($urandom_range(4000, 0)) * 16 - 32000;
        send_measurement(32'(z), $urandom_range(32'h0008_0000, 32'h0000_0100), ts);
      end else begin
        send_measurement($urandom, $urandom, 18'($urandom_range(262143)));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // zero noise after reset: zero variance is degenerate, zero step holds the state
    send_measurement(32'sd0, 32'd0, 18'd0);
    send_measurement(32'sh7fff_ffff, 32'd0, 18'h3ffff);
    send_measurement(32'sh8000_0000, 32'h0001_0000, 18'd0);
    send_measurement(32'sh0001_0000, 32'hffff_ffff, 18'h1_0000);
    send_measurement(32'sh8000_0000, 32'd1, 18'd1);
    write_accel_var(32'hffff_ffff);
    send_measurement(32'sh7fff_ffff, 32'd0, 18'h3ffff);
    send_measurement(32'sh8000_0000, 32'd0, 18'h3ffff);
    send_measurement(32'sh7fff_ffff, 32'hffff_ffff, 18'h3ffff);
    send_measurement(32'sd0, 32'd0, 18'd0);
    send_measurement(-32'sd1, 32'd1, 18'd1);
    write_accel_var(32'h0001_0000);
    send_measurement(32'sh0010_0000, 32'h0000_4000, 18'h0_1999);
    send_measurement(32'sh0011_0000, 32'h0000_4000, 18'h0_1999);
    send_measurement(32'sh0012_8000, 32'h0000_4000, 18'h0_1999);
    send_measurement(32'sh8000_0000, 32'h0000_0001, 18'h2_0000);
    send_measurement(32'sh7fff_ffff, 32'hffff_ffff, 18'h0_0001);

    send_idle = 17; recv_idle = 74;
    send_random(480);
    write_accel_var($urandom_range(32'h0010_0000, 32'h0000_0100));
    send_idle = 74; recv_idle = 17;
    send_random(480);
    write_accel_var(32'd0);
    send_idle = 0; recv_idle = 0;
    send_random(240);
    write_accel_var($urandom);
    send_random(235);
    drain();

    $display("Sent %0d measurements over four noise settings; %0d estimates checked,",
             items_sent, tracker.checked);
    $display("%0d with correction skipped and %0d with clamping", tracker.degen_seen,
             tracker.sat_seen);
    if (tracker.mismatches == 0 && tracker.est_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d estimates missing", tracker.mismatches,
               tracker.est_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

### sim.f
rtl/core/kav_pkg.sv
rtl/core/kav_mul.sv
rtl/core/kav_div.sv
rtl/core/kalman_altitude_velocity_filter.sv
sim/tb.sv
